@@ rtl/stwa_pkg.sv @@
package stwa_pkg;

    localparam int WL_W      = 16;              // wavelength, Q12.4
    localparam int PART_W    = 24;              // refractive part, Q8.16
    localparam int CFG_W     = 8;               // entry_count register
    localparam int INIDX_W   = 7;               // entry_index field
    localparam int POS_W     = WL_W + 2;        // signed clip positions
    localparam int TERM_W    = WL_W + 1;        // 2b-ca-cb and ca+cb-2a
    localparam int SPAN_W    = WL_W + 1;        // 2(b-a)
    localparam int DIFF_W    = 5;               // cb-ca, at most 16
    localparam int PROD_W    = PART_W + TERM_W;
    localparam int NUM_W     = 48;
    localparam int SUM_W     = 40;
    localparam int ENT_W     = WL_W + 2 * PART_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = 6;
    localparam int HALF_WIN  = 8;               // 0.5 nm in Q12.4
    localparam int AVG_LSB   = 4;               // divide by window width 16

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [2:0] REG_ENTRY_COUNT = 3'd0;
    localparam logic [CFG_W-1:0] ENTRY_COUNT_RESET = 8'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_ENDS,
        ST_CLIP,
        ST_SEG_RD,
        ST_SEG_CHK,
        ST_MUL2,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_we;
        logic query_ld;
        logic rd_first;
        logic clip_ld;
        logic seg_clr;
        logic seg_inc;
        logic mul1_ld;
        logic mul2_ld;
        logic div_step;
        logic acc_clr;
        logic acc_ld;
        logic hit_ld;
        logic out_ld;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic skip;
        logic seg_last;
        logic div_last;
        logic out_full;
    } sts_t;

endpackage

@@ rtl/stwa_ctrl.sv @@
module stwa_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            func,
    output logic            item_stall,
    input  stwa_pkg::sts_t  sts,
    output stwa_pkg::cmd_t  cmd
);

    stwa_pkg::state_t state_reg;
    stwa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stwa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            stwa_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    if (func == stwa_pkg::FUNC_QUERY)
                    begin
                        cmd.query_ld = 1'b1;
                        state_next   = stwa_pkg::ST_RD_ENDS;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            stwa_pkg::ST_RD_ENDS:
            begin
                cmd.rd_first = 1'b1;
                state_next   = stwa_pkg::ST_CLIP;
            end
            stwa_pkg::ST_CLIP:
            begin
                cmd.clip_ld = 1'b1;
                cmd.acc_clr = 1'b1;
                cmd.hit_ld  = 1'b1;
                cmd.seg_clr = 1'b1;
                state_next  = sts.empty ? stwa_pkg::ST_DONE : stwa_pkg::ST_SEG_RD;
            end
            stwa_pkg::ST_SEG_RD:
            begin
                state_next = stwa_pkg::ST_SEG_CHK;
            end
            stwa_pkg::ST_SEG_CHK:
            begin
                if (sts.skip)
                begin
                    if (sts.seg_last)
                    begin
                        state_next = stwa_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.seg_inc = 1'b1;
                        state_next  = stwa_pkg::ST_SEG_RD;
                    end
                end
                else
                begin
                    cmd.mul1_ld = 1'b1;
                    state_next  = stwa_pkg::ST_MUL2;
                end
            end
            stwa_pkg::ST_MUL2:
            begin
                cmd.mul2_ld = 1'b1;
                state_next  = stwa_pkg::ST_DIV;
            end
            stwa_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = stwa_pkg::ST_ACC;
                end
            end
            stwa_pkg::ST_ACC:
            begin
                cmd.acc_ld = 1'b1;
                if (sts.seg_last)
                begin
                    state_next = stwa_pkg::ST_DONE;
                end
                else
                begin
                    cmd.seg_inc = 1'b1;
                    state_next  = stwa_pkg::ST_SEG_RD;
                end
            end
            stwa_pkg::ST_DONE:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = stwa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stwa_pkg::ST_IDLE;
            end
        endcase
    end

    a_out_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> !sts.out_full)
        else $error("result register overwritten while stalled");

    a_div_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stwa_pkg::ST_DIV && sts.div_last) |=> state_reg == stwa_pkg::ST_ACC)
        else $error("divider finish not followed by accumulate");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stwa_pkg::ST_IDLE && item_valid && func == stwa_pkg::FUNC_QUERY)
        |=> item_stall)
        else $error("query accepted without entering busy state");

endmodule

@@ rtl/stwa_datapath.sv @@
module stwa_datapath
#(
    parameter int TABLE_DEPTH = 128
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  stwa_pkg::cmd_t                    cmd,
    output stwa_pkg::sts_t                    sts,
    input  logic [stwa_pkg::CFG_W-1:0]        entry_count,
    input  logic [stwa_pkg::INIDX_W-1:0]      entry_index,
    input  logic [stwa_pkg::WL_W-1:0]         wavelength,
    input  logic [stwa_pkg::PART_W-1:0]       real_part,
    input  logic [stwa_pkg::PART_W-1:0]       imag_part,
    input  logic                              result_stall,
    output logic                              result_valid,
    output logic [stwa_pkg::PART_W-1:0]       real_average,
    output logic [stwa_pkg::PART_W-1:0]       imag_average,
    output logic                              window_hit
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > stwa_pkg::CFG_W) ? CNT_W : stwa_pkg::CFG_W;
    localparam int PW    = stwa_pkg::PART_W;
    localparam int WW    = stwa_pkg::WL_W;
    localparam int NW    = stwa_pkg::NUM_W;
    localparam int SW    = stwa_pkg::SPAN_W;

    // table memory: {wavelength, real, imag}
    logic [stwa_pkg::ENT_W-1:0] mem [TABLE_DEPTH];
    logic [stwa_pkg::ENT_W-1:0] rd_a_reg;
    logic [stwa_pkg::ENT_W-1:0] rd_b_reg;

    logic [CMP_W-1:0] count_x;
    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] last_seg;
    logic [IDX_W-1:0] waddr;
    logic             idx_ok;
    logic [IDX_W-1:0] seg_reg;

    always_comb
    begin
        count_x = CMP_W'(entry_count);
        if (count_x < CMP_W'(2))
        begin
            n_eff = CNT_W'(2);
        end
        else if (count_x > CMP_W'(TABLE_DEPTH))
        begin
            n_eff = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = CNT_W'(count_x);
        end
        last_idx = IDX_W'(n_eff - CNT_W'(1));
        last_seg = IDX_W'(n_eff - CNT_W'(2));
        addr_a   = cmd.rd_first ? '0 : seg_reg;
        addr_b   = cmd.rd_first ? last_idx : IDX_W'(seg_reg + IDX_W'(1));
        waddr    = IDX_W'(entry_index);
        idx_ok   = (int'(entry_index) < TABLE_DEPTH);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && idx_ok)
        begin
            mem[waddr] <= {wavelength, real_part, imag_part};
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // field views of the two read words
    logic [WW-1:0] wa;
    logic [WW-1:0] wb;
    logic [PW-1:0] ra;
    logic [PW-1:0] rb;
    logic [PW-1:0] ia;
    logic [PW-1:0] ib;

    assign wa = rd_a_reg[stwa_pkg::ENT_W-1 -: WW];
    assign wb = rd_b_reg[stwa_pkg::ENT_W-1 -: WW];
    assign ra = rd_a_reg[2*PW-1 -: PW];
    assign rb = rd_b_reg[2*PW-1 -: PW];
    assign ia = rd_a_reg[PW-1:0];
    assign ib = rd_b_reg[PW-1:0];

    // window clip
    logic [WW-1:0]                      w_reg;
    logic signed [stwa_pkg::POS_W-1:0]  start_reg;
    logic signed [stwa_pkg::POS_W-1:0]  end_reg;
    logic signed [stwa_pkg::POS_W-1:0]  lo;
    logic signed [stwa_pkg::POS_W-1:0]  hi;
    logic signed [stwa_pkg::POS_W-1:0]  pa;
    logic signed [stwa_pkg::POS_W-1:0]  pb;
    logic signed [stwa_pkg::POS_W-1:0]  start_c;
    logic signed [stwa_pkg::POS_W-1:0]  end_c;
    logic signed [stwa_pkg::POS_W-1:0]  ca;
    logic signed [stwa_pkg::POS_W-1:0]  cb;
    logic signed [stwa_pkg::POS_W:0]    ta_s;
    logic signed [stwa_pkg::POS_W:0]    tb_s;
    logic signed [stwa_pkg::POS_W-1:0]  d_s;
    logic signed [stwa_pkg::POS_W-1:0]  span_s;

    always_comb
    begin
        lo      = $signed({2'b00, w_reg}) - stwa_pkg::POS_W'(stwa_pkg::HALF_WIN);
        hi      = $signed({2'b00, w_reg}) + stwa_pkg::POS_W'(stwa_pkg::HALF_WIN);
        pa      = $signed({2'b00, wa});
        pb      = $signed({2'b00, wb});
        start_c = (lo > pa) ? lo : pa;
        end_c   = (hi < pb) ? hi : pb;
        ca      = (pa > start_reg) ? pa : start_reg;
        cb      = (pb < end_reg) ? pb : end_reg;
        ta_s    = (stwa_pkg::POS_W+1)'(2) * (stwa_pkg::POS_W+1)'(pb)
                  - (stwa_pkg::POS_W+1)'(ca) - (stwa_pkg::POS_W+1)'(cb);
        tb_s    = (stwa_pkg::POS_W+1)'(ca) + (stwa_pkg::POS_W+1)'(cb)
                  - (stwa_pkg::POS_W+1)'(2) * (stwa_pkg::POS_W+1)'(pa);
        d_s     = cb - ca;
        span_s  = pb - pa;
    end

    // multiply, divide and accumulate lanes
    logic [stwa_pkg::PROD_W-1:0]    pr_ra_reg;
    logic [stwa_pkg::PROD_W-1:0]    pr_rb_reg;
    logic [stwa_pkg::PROD_W-1:0]    pr_ia_reg;
    logic [stwa_pkg::PROD_W-1:0]    pr_ib_reg;
    logic [stwa_pkg::DIFF_W-1:0]    d_reg;
    logic [SW-1:0]                  den_reg;
    logic [NW-1:0]                  num_r_reg;
    logic [NW-1:0]                  num_i_reg;
    logic [SW-1:0]                  rem_r_reg;
    logic [SW-1:0]                  rem_i_reg;
    logic [stwa_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [stwa_pkg::SUM_W-1:0]     sum_r_reg;
    logic [stwa_pkg::SUM_W-1:0]     sum_i_reg;
    logic                           hit_reg;
    logic [stwa_pkg::PROD_W:0]      tot_r;
    logic [stwa_pkg::PROD_W:0]      tot_i;
    logic [SW:0]                    sh_r;
    logic [SW:0]                    sh_i;
    logic                           q_r;
    logic                           q_i;
    logic [SW-1:0]                  rem_r_next;
    logic [SW-1:0]                  rem_i_next;

    always_comb
    begin
        tot_r = (stwa_pkg::PROD_W+1)'(pr_ra_reg) + (stwa_pkg::PROD_W+1)'(pr_rb_reg);
        tot_i = (stwa_pkg::PROD_W+1)'(pr_ia_reg) + (stwa_pkg::PROD_W+1)'(pr_ib_reg);
        sh_r  = {rem_r_reg, num_r_reg[NW-1]};
        sh_i  = {rem_i_reg, num_i_reg[NW-1]};
        q_r   = (sh_r >= {1'b0, den_reg});
        q_i   = (sh_i >= {1'b0, den_reg});
        rem_r_next = q_r ? SW'(sh_r - {1'b0, den_reg}) : SW'(sh_r);
        rem_i_next = q_i ? SW'(sh_i - {1'b0, den_reg}) : SW'(sh_i);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_ld)
        begin
            w_reg <= wavelength;
        end
        if (cmd.clip_ld)
        begin
            start_reg <= start_c;
            end_reg   <= end_c;
        end
        if (cmd.mul1_ld)
        begin
            pr_ra_reg <= stwa_pkg::PROD_W'(ra) * stwa_pkg::PROD_W'(ta_s[stwa_pkg::TERM_W-1:0]);
            pr_rb_reg <= stwa_pkg::PROD_W'(rb) * stwa_pkg::PROD_W'(tb_s[stwa_pkg::TERM_W-1:0]);
            pr_ia_reg <= stwa_pkg::PROD_W'(ia) * stwa_pkg::PROD_W'(ta_s[stwa_pkg::TERM_W-1:0]);
            pr_ib_reg <= stwa_pkg::PROD_W'(ib) * stwa_pkg::PROD_W'(tb_s[stwa_pkg::TERM_W-1:0]);
            d_reg     <= d_s[stwa_pkg::DIFF_W-1:0];
            den_reg   <= {span_s[SW-2:0], 1'b0};
        end
        if (cmd.mul2_ld)
        begin
            num_r_reg <= NW'(tot_r) * NW'(d_reg);
            num_i_reg <= NW'(tot_i) * NW'(d_reg);
            rem_r_reg <= '0;
            rem_i_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_r_reg <= {num_r_reg[NW-2:0], q_r};
            num_i_reg <= {num_i_reg[NW-2:0], q_i};
            rem_r_reg <= rem_r_next;
            rem_i_reg <= rem_i_next;
        end
        if (cmd.acc_clr)
        begin
            sum_r_reg <= '0;
            sum_i_reg <= '0;
        end
        else if (cmd.acc_ld)
        begin
            sum_r_reg <= sum_r_reg + stwa_pkg::SUM_W'(num_r_reg);
            sum_i_reg <= sum_i_reg + stwa_pkg::SUM_W'(num_i_reg);
        end
        if (cmd.hit_ld)
        begin
            hit_reg <= (end_c > start_c);
        end
        if (cmd.out_ld)
        begin
            real_average <= sum_r_reg[stwa_pkg::AVG_LSB +: PW];
            imag_average <= sum_i_reg[stwa_pkg::AVG_LSB +: PW];
            window_hit   <= hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg      <= '0;
            div_cnt_reg  <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            if (cmd.seg_clr)
            begin
                seg_reg <= '0;
            end
            else if (cmd.seg_inc)
            begin
                seg_reg <= IDX_W'(seg_reg + IDX_W'(1));
            end
            if (cmd.mul2_ld)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= stwa_pkg::DIV_CNT_W'(div_cnt_reg + 1'b1);
            end
            if (cmd.out_ld)
            begin
                result_valid <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.empty    = (end_c <= start_c);
        sts.skip     = (ca >= cb);
        sts.seg_last = (seg_reg == last_seg);
        sts.div_last = (div_cnt_reg == stwa_pkg::DIV_CNT_W'(stwa_pkg::DIV_STEPS - 1));
        sts.out_full = result_valid && result_stall;
    end

    a_rise_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.out_ld))
        else $error("result appeared without a load");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !window_hit) |-> (real_average == '0 && imag_average == '0))
        else $error("window miss with nonzero average");

    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul1_ld |-> (CNT_W'(seg_reg) < CNT_W'(n_eff - CNT_W'(1))))
        else $error("segment index beyond last segment");

endmodule

@@ rtl/spectral_table_window_average.sv @@
// Channel   | Handshake                  | Word
// ----------+----------------------------+-------------------------------------------
// item      | item_valid / item_stall    | func, entry_index, wavelength, real_part,
//           |                            | imag_part
// result    | result_valid / result_stall| real_average, imag_average, window_hit
// config    | APB psel/penable/pwrite    | entry_count at byte address 0
//
// A load word writes one table entry in the cycle it is accepted; the next word
// may follow at once. A query steps through up to n-1 segments, n the entry count,
// and holds off new words until it is done: each segment the window overlaps
// runs the 48-step restoring dividers of both lanes (one quotient bit a cycle).
// Reset clears the controller, the result valid and entry_count (to 2); the table
// itself is undefined until loaded. A stalled result holds in its register while
// the next word is already taken.
module spectral_table_window_average
#(
    parameter int TABLE_DEPTH = 128
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // item channel
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         func,
    input  logic [stwa_pkg::INIDX_W-1:0] entry_index,
    input  logic [stwa_pkg::WL_W-1:0]    wavelength,
    input  logic [stwa_pkg::PART_W-1:0]  real_part,
    input  logic [stwa_pkg::PART_W-1:0]  imag_part,
    // result channel
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [stwa_pkg::PART_W-1:0]  real_average,
    output logic [stwa_pkg::PART_W-1:0]  imag_average,
    output logic                         window_hit
);

    logic [stwa_pkg::CFG_W-1:0] entry_count_reg;
    logic                       cfg_hit;
    stwa_pkg::cmd_t             cmd;
    stwa_pkg::sts_t             sts;

    // Register 0 is decoded from paddr[2] alone, so addresses 0 to 3 all reach it;
    // addresses 4 to 7 read zero and drop writes.
    assign pready  = 1'b1;
    assign cfg_hit = ({paddr[2], 2'b00} == stwa_pkg::REG_ENTRY_COUNT);
    assign prdata  = cfg_hit ? 32'(entry_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= stwa_pkg::ENTRY_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            entry_count_reg <= pwdata[stwa_pkg::CFG_W-1:0];
        end
    end

    stwa_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .func       (func),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    stwa_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .entry_count  (entry_count_reg),
        .entry_index  (entry_index),
        .wavelength   (wavelength),
        .real_part    (real_part),
        .imag_part    (imag_part),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .real_average (real_average),
        .imag_average (imag_average),
        .window_hit   (window_hit)
    );

endmodule

@@ tb/testbench.sv @@
module testbench;

    localparam int          DEPTH            = 128;
    localparam logic [2:0]  ADDR_ENTRY_COUNT = 3'(stwa_pkg::REG_ENTRY_COUNT << 2);
    // next word slot in the register map; nothing lives there
    localparam logic [2:0]  ADDR_UNMAPPED    = 3'd4;
    // a load lands in the cycle it is taken, so a short settle is plenty
    localparam int          SETTLE_CYCLES    = 10;

    typedef struct packed {
        logic [stwa_pkg::PART_W-1:0] re;
        logic [stwa_pkg::PART_W-1:0] im;
        logic                        hit;
    } avg_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          item_valid;
    logic                          item_stall;
    logic                          func;
    logic [stwa_pkg::INIDX_W-1:0]  entry_index;
    logic [stwa_pkg::WL_W-1:0]     wavelength;
    logic [stwa_pkg::PART_W-1:0]   real_part;
    logic [stwa_pkg::PART_W-1:0]   imag_part;
    logic                          result_valid;
    logic                          result_stall;
    logic [stwa_pkg::PART_W-1:0]   real_average;
    logic [stwa_pkg::PART_W-1:0]   imag_average;
    logic                          window_hit;

    // shadow copy of the block state
    logic [stwa_pkg::WL_W-1:0]     tbl_wl [DEPTH];
    logic [stwa_pkg::PART_W-1:0]   tbl_re [DEPTH];
    logic [stwa_pkg::PART_W-1:0]   tbl_im [DEPTH];
    logic [stwa_pkg::CFG_W-1:0]    cfg_count;

    avg_t                 expected_avgs[$];
    avg_t                 want;
    avg_t                 got;

    int                   tx_idle_pct;
    int                   rx_idle_pct;
    int                   words_sent;
    int                   loads_sent;
    int                   queries_sent;
    int                   hits_seen;
    int                   misses_seen;
    int                   results_seen;
    int                   mismatches;

    spectral_table_window_average u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .entry_index  (entry_index),
        .wavelength   (wavelength),
        .real_part    (real_part),
        .imag_part    (imag_part),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .real_average (real_average),
        .imag_average (imag_average),
        .window_hit   (window_hit)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Exact trapezoid area of one clipped segment, truncated.
    function automatic longint unsigned trapezoid(input longint a, input longint b,
                                                  input longint ca, input longint cb,
                                                  input longint unsigned fa,
                                                  input longint unsigned fb);
        longint unsigned width_part;
        longint unsigned far_term;
        longint unsigned near_term;
        longint unsigned span;
        width_part = longint'(cb - ca);
        far_term   = longint'(2 * b - ca - cb);
        near_term  = longint'(ca + cb - 2 * a);
        span       = longint'(2 * (b - a));
        return width_part * (fa * far_term + fb * near_term) / span;
    endfunction

    // Window mean over [w-8, w+8], clipped to the table span.
    function automatic avg_t window_average(input logic [stwa_pkg::WL_W-1:0] w);
        avg_t            r;
        int              n;
        longint          lo;
        longint          hi;
        longint          start;
        longint          stop;
        longint          a;
        longint          b;
        longint          ca;
        longint          cb;
        longint unsigned sum_re;
        longint unsigned sum_im;
        n = (cfg_count < 2) ? 2 : ((cfg_count > DEPTH) ? DEPTH : int'(cfg_count));
        lo     = longint'(w) - stwa_pkg::HALF_WIN;
        hi     = longint'(w) + stwa_pkg::HALF_WIN;
        start  = (lo > longint'(tbl_wl[0])) ? lo : longint'(tbl_wl[0]);
        stop   = (hi < longint'(tbl_wl[n-1])) ? hi : longint'(tbl_wl[n-1]);
        r      = '0;
        sum_re = 0;
        sum_im = 0;
        if (stop <= start)
            return r;
        for (int i = 0; i + 1 < n; i++)
        begin
            a  = longint'(tbl_wl[i]);
            b  = longint'(tbl_wl[i+1]);
            ca = (a > start) ? a : start;
            cb = (b < stop) ? b : stop;
            if (ca >= cb)
                continue;
            sum_re += trapezoid(a, b, ca, cb, 64'(tbl_re[i]), 64'(tbl_re[i+1]));
            sum_im += trapezoid(a, b, ca, cb, 64'(tbl_im[i]), 64'(tbl_im[i+1]));
        end
        r.re  = stwa_pkg::PART_W'(sum_re >> stwa_pkg::AVG_LSB);
        r.im  = stwa_pkg::PART_W'(sum_im >> stwa_pkg::AVG_LSB);
        r.hit = 1'b1;
        return r;
    endfunction

    // Result checker: compare every taken result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            got = '{re: real_average, im: imag_average, hit: window_hit};
            if (expected_avgs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: re %h im %h hit %b", got.re, got.im, got.hit);
            end
            else
            begin
                want = expected_avgs.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: expected re %h im %h hit %b, got re %h im %h hit %b",
                                 results_seen, want.re, want.im, want.hit,
                                 got.re, got.im, got.hit);
                end
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Send one word; hold it until taken, then update the shadow state.
    task automatic send_word(input logic f_func,
                             input logic [stwa_pkg::INIDX_W-1:0] f_index,
                             input logic [stwa_pkg::WL_W-1:0] f_wl,
                             input logic [stwa_pkg::PART_W-1:0] f_re,
                             input logic [stwa_pkg::PART_W-1:0] f_im);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        func        <= f_func;
        entry_index <= f_index;
        wavelength  <= f_wl;
        real_part   <= f_re;
        imag_part   <= f_im;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
        if (f_func == stwa_pkg::FUNC_LOAD)
        begin
            loads_sent++;
            tbl_wl[f_index] = f_wl;
            tbl_re[f_index] = f_re;
            tbl_im[f_index] = f_im;
        end
        else
        begin
            queries_sent++;
            want = window_average(f_wl);
            if (want.hit)
                hits_seen++;
            else
                misses_seen++;
            expected_avgs.push_back(want);
        end
    endtask

    task automatic query(input logic [stwa_pkg::WL_W-1:0] w);
        send_word(stwa_pkg::FUNC_QUERY, stwa_pkg::INIDX_W'($urandom), w,
                  stwa_pkg::PART_W'($urandom), stwa_pkg::PART_W'($urandom));
    endtask

    // Hold the sender until every pending result is back, then settle.
    task automatic drain();
        item_valid <= 1'b0;
        while (expected_avgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the write at the access edge.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ENTRY_COUNT)
            cfg_count = data[stwa_pkg::CFG_W-1:0];
    endtask

    task automatic set_count(input logic [31:0] value);
        drain();
        apb_write(ADDR_ENTRY_COUNT, value);
    endtask

    // Fill every entry, so no query ever reads an unloaded entry.
    task automatic test_table_fill();
        for (int i = 0; i < DEPTH; i++)
            send_word(stwa_pkg::FUNC_LOAD, stwa_pkg::INIDX_W'(i),
                      (i == DEPTH - 1) ? stwa_pkg::WL_W'(16'hFFFF)
                                       : stwa_pkg::WL_W'(i * 516),
                      stwa_pkg::PART_W'($urandom), stwa_pkg::PART_W'($urandom));
        // extremes of the parts at both ends of the table
        send_word(stwa_pkg::FUNC_LOAD, 7'd0, 16'd0, 24'h000000, 24'hFFFFFF);
        send_word(stwa_pkg::FUNC_LOAD, 7'd1, 16'd516, 24'hFFFFFF, 24'h000000);
        send_word(stwa_pkg::FUNC_LOAD, 7'd126, stwa_pkg::WL_W'(126 * 516),
                  24'hFFFFFF, 24'hFFFFFF);
        send_word(stwa_pkg::FUNC_LOAD, 7'd127, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    endtask

    // Window edges: below zero, past the top, on a point, mid segment.
    task automatic test_corner_queries();
        set_count(DEPTH);
        query(16'h0000);
        query(16'hFFFF);
        query(16'd65530);
        query(16'd258);
        query(16'd516);
        query(16'd40000);
        query(16'd4);
    endtask

    // Counts outside 2..128 clamp; an unmapped write changes nothing.
    task automatic test_count_clamp();
        set_count(0);
        query(16'd258);
        query(16'd600);
        set_count(1);
        query(16'd510);
        set_count(255);
        query(16'hFFFF);
        drain();
        apb_write(ADDR_UNMAPPED, 32'd5);
        query(16'd65530);
        query(16'd64000);
    endtask

    // A segment running backward is skipped; the span may close up entirely.
    task automatic test_unordered_table();
        set_count(3);
        send_word(stwa_pkg::FUNC_LOAD, 7'd2, 16'd100,
                  stwa_pkg::PART_W'($urandom), stwa_pkg::PART_W'($urandom));
        query(16'd90);
        query(16'd300);
        query(16'd100);
        send_word(stwa_pkg::FUNC_LOAD, 7'd2, 16'd1032,
                  stwa_pkg::PART_W'($urandom), stwa_pkg::PART_W'($urandom));
        query(16'd520);
    endtask

    // Random tables of random size and spacing, each followed by a burst of queries.
    task automatic test_random_tables(input int goal);
        int pick;
        int n_cfg;
        int n_eff;
        int gap;
        int base;
        int cur;
        int lo_w;
        int hi_w;
        int w;
        while (words_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                n_cfg = DEPTH;
            else if (pick < 9)
                n_cfg = $urandom_range(0, 1);
            else if (pick < 12)
                n_cfg = 255;
            else
                n_cfg = $urandom_range(2, 16);
            n_eff = (n_cfg < 2) ? 2 : ((n_cfg > DEPTH) ? DEPTH : n_cfg);
            gap   = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 40);
            base  = $urandom_range(0, 65535 - (n_eff - 1) * gap);
            if ($urandom_range(9) == 0)
                base = 65535 - (n_eff - 1) * gap;
            else if ($urandom_range(9) == 0)
                base = 0;
            set_count(n_cfg);
            cur = base;
            for (int i = 0; i < n_eff; i++)
            begin
                // now and then drop a point behind its neighbor
                if (i > 0 && $urandom_range(99) < 8)
                    w = cur - $urandom_range(0, gap);
                else
                    w = cur;
                w = (w < 0) ? 0 : ((w > 65535) ? 65535 : w);
                send_word(stwa_pkg::FUNC_LOAD, stwa_pkg::INIDX_W'(i), stwa_pkg::WL_W'(w),
                          stwa_pkg::PART_W'($urandom), stwa_pkg::PART_W'($urandom));
                cur += gap;
            end
            lo_w = tbl_wl[0];
            hi_w = tbl_wl[n_eff-1];
            if (hi_w < lo_w)
                hi_w = lo_w;
            repeat ($urandom_range(4, 12))
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    // overwrite an entry anywhere; all were loaded at the start
                    send_word(stwa_pkg::FUNC_LOAD, stwa_pkg::INIDX_W'($urandom),
                              stwa_pkg::WL_W'($urandom), stwa_pkg::PART_W'($urandom),
                              stwa_pkg::PART_W'($urandom));
                end
                else if (pick < 15)
                    query(tbl_wl[$urandom_range(0, n_eff - 1)]);
                else if (pick < 25)
                    query(stwa_pkg::WL_W'($urandom));
                else
                begin
                    w = lo_w - 24 + $urandom_range(0, hi_w - lo_w + 48);
                    query(stwa_pkg::WL_W'((w < 0) ? 0 : ((w > 65535) ? 65535 : w)));
                end
            end
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        item_valid   <= 1'b0;
        func         <= stwa_pkg::FUNC_LOAD;
        entry_index  <= '0;
        wavelength   <= '0;
        real_part    <= '0;
        imag_part    <= '0;
        result_stall <= 1'b0;
        cfg_count    = stwa_pkg::ENTRY_COUNT_RESET;
        tx_idle_pct  = 8;
        rx_idle_pct  = 73;
        words_sent   = 0;
        loads_sent   = 0;
        queries_sent = 0;
        hits_seen    = 0;
        misses_seen  = 0;
        results_seen = 0;
        mismatches   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_fill();
        test_corner_queries();
        test_count_clamp();
        test_unordered_table();

        // sender mostly busy, receiver mostly stalling
        test_random_tables(700);
        // swap the pressure
        tx_idle_pct = 73;
        rx_idle_pct = 8;
        test_random_tables(1300);
        // back to back on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_tables(1900);

        drain();
        repeat (20) @(posedge clk);
        if (expected_avgs.size() != 0)
            mismatches++;
        $display("covered %0d words: %0d table loads, %0d queries (%0d in span, %0d outside)",
                 words_sent, loads_sent, queries_sent, hits_seen, misses_seen);
        $display("results checked %0d, mismatches %0d", results_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #300000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
